FILE: hw/rtl/rmeu_pkg.sv
package rmeu_pkg;

    typedef enum logic [3:0] {
        OP_MRR  = 4'd0,
        OP_MVI  = 4'd1,
        OP_LDMR = 4'd2,
        OP_STRM = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_AND  = 4'd8,
        OP_OR   = 4'd9,
        OP_XOR  = 4'd10,
        OP_NOT  = 4'd11,
        OP_JMP  = 4'd12,
        OP_JZ   = 4'd13,
        OP_JN   = 4'd14,
        OP_OUT  = 4'd15
    } op_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_IMM  = 2'd2;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_KIND  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    localparam int OFFSET_W = 12;
    localparam int FETCH_W  = 12;

    typedef struct packed {
        op_t                opcode;
        logic [1:0]         first_kind;
        logic signed [15:0] first_value;
        logic [1:0]         second_kind;
        logic signed [15:0] second_value;
        logic [1:0]         third_kind;
        logic signed [15:0] third_value;
    } cmd_t;

    typedef struct packed {
        logic [FETCH_W-1:0] next_fetch;
        logic               shown_valid;
        logic [2:0]         shown_register;
        logic signed [15:0] shown_value;
        logic [1:0]         fault_code;
    } res_t;

    // required kinds of first, second and third operand
    function automatic logic [5:0] kind_need(input op_t op);
        logic [5:0] need;
        unique case (op)
            OP_MRR, OP_LDMR, OP_STRM, OP_INC, OP_DEC, OP_NOT:
                need = {KIND_REG, KIND_REG, KIND_NONE};
            OP_MVI, OP_JZ, OP_JN:
                need = {KIND_REG, KIND_IMM, KIND_NONE};
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
                need = {KIND_REG, KIND_REG, KIND_REG};
            OP_JMP:
                need = {KIND_IMM, KIND_NONE, KIND_NONE};
            OP_OUT:
                need = {KIND_REG, KIND_NONE, KIND_NONE};
            default:
                need = {KIND_NONE, KIND_NONE, KIND_NONE};
        endcase
        return need;
    endfunction

    function automatic logic uses_third(input op_t op);
        logic r;
        case (op) inside
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: r = 1'b1;
            default:                               r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/register_machine_execute_unit.sv
// A word is registered in the execute stage, then its result in the result register.
// Throughput: one word per cycle; the result register stalls the whole
// pipeline only while a result waits to be taken.
// Register file and data RAM are synchronous memories; register reads are forwarded.
// Reset: registers read as zero, fetch counter and program offset clear, and
// the data RAM is swept to zero with cmd_ready low.
module register_machine_execute_unit
    import rmeu_pkg::*;
#(
    parameter int DATA_DEPTH    = 4096,
    parameter int PROGRAM_DEPTH = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [OFFSET_W-1:0] cfg_write_data,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res
);

    localparam int DA_W    = $clog2(DATA_DEPTH);
    localparam int PC_W    = $clog2(PROGRAM_DEPTH);
    localparam int PC_BIAS = ((32768 + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH) * PROGRAM_DEPTH;
    localparam int JT_W    = 18;

    // pipeline control
    logic adv;
    logic accept;

    // data RAM
    logic [15:0]     dmem [DATA_DEPTH];
    logic [15:0]     dmem_q_reg;
    logic            dmem_we;
    logic [DA_W-1:0] dmem_waddr;
    logic [15:0]     dmem_wdata;
    logic            dmem_re;
    logic [DA_W-1:0] dmem_raddr;
    logic            clear_reg;
    logic [DA_W-1:0] clr_addr_reg;

    // register file
    logic [15:0] rf_mem [8];
    logic [7:0]  rf_valid_reg;
    logic [15:0] rfa_q_reg;
    logic [15:0] rfb_q_reg;
    logic [2:0]  rfa_addr;
    logic [2:0]  rfb_addr;
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;

    // write history for read-during-write
    logic        hist_valid_reg;
    logic [2:0]  hist_addr_reg;
    logic [15:0] hist_data_reg;

    // architectural registers
    logic [OFFSET_W-1:0] offset_reg;
    logic [PC_W-1:0]     fetch_reg;
    logic [PC_W-1:0]     fetch_next;

    // execute stage
    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [5:0]  need;
    logic [1:0]  fault;
    logic [2:0]  d_addr;
    logic [2:0]  a_addr;
    logic [2:0]  b_addr;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic [15:0] alu;
    logic        wr_en;
    logic        is_load;
    logic        is_store;
    logic        taken;
    logic [15:0] jimm;
    logic [JT_W-1:0] jsum;
    logic [31:0] jsum_ext;
    logic [PC_W-1:0] jtarget;
    logic [PC_W-1:0] fetch_inc;
    logic [31:0] fetch_ext;
    logic [31:0] ram_addr_ext;
    res_t        res_next;

    // write-back / result stage
    logic        s2_valid_reg;
    logic        s2_wr_en_reg;
    logic        s2_load_reg;
    logic [2:0]  s2_waddr_reg;
    logic [15:0] s2_wdata_reg;
    res_t        s2_res_reg;
    logic [15:0] s2_value;

    assign adv       = !s2_valid_reg || res_ready;
    assign cmd_ready = adv && !clear_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = s2_valid_reg;
    assign res       = s2_res_reg;

    // register file ports
    assign rfa_addr = cmd.second_value[2:0];
    assign rfb_addr = uses_third(cmd.opcode) ? cmd.third_value[2:0] : cmd.first_value[2:0];
    assign s2_value = s2_load_reg ? dmem_q_reg : s2_wdata_reg;
    assign rf_we    = adv && s2_valid_reg && s2_wr_en_reg;
    assign rf_waddr = s2_waddr_reg;
    assign rf_wdata = s2_value;

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (adv)
        begin
            rfa_q_reg <= rf_valid_reg[rfa_addr] ? rf_mem[rfa_addr] : 16'h0000;
            rfb_q_reg <= rf_valid_reg[rfb_addr] ? rf_mem[rfb_addr] : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg   <= '0;
            hist_valid_reg <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (adv)
            begin
                hist_valid_reg <= rf_we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hist_addr_reg <= rf_waddr;
            hist_data_reg <= rf_wdata;
        end
    end

    function automatic logic [15:0] fwd(input logic [2:0] addr, input logic [15:0] q);
        logic [15:0] v;
        if (s2_valid_reg && s2_wr_en_reg && s2_waddr_reg == addr)
        begin
            v = s2_value;
        end
        else if (hist_valid_reg && hist_addr_reg == addr)
        begin
            v = hist_data_reg;
        end
        else
        begin
            v = q;
        end
        return v;
    endfunction

    // execute
    assign d_addr = s1_cmd_reg.first_value[2:0];
    assign a_addr = s1_cmd_reg.second_value[2:0];
    assign b_addr = uses_third(s1_cmd_reg.opcode) ? s1_cmd_reg.third_value[2:0] : d_addr;
    assign need   = kind_need(s1_cmd_reg.opcode);

    always_comb
    begin
        op_a = fwd(a_addr, rfa_q_reg);
        op_b = fwd(b_addr, rfb_q_reg);
    end

    always_comb
    begin
        fault = FAULT_OK;
        if (s1_cmd_reg.first_kind != need[5:4] || s1_cmd_reg.second_kind != need[3:2]
            || s1_cmd_reg.third_kind != need[1:0])
        begin
            fault = FAULT_KIND;
        end
        else if ((need[5:4] == KIND_REG && s1_cmd_reg.first_value[15:3] != '0)
            || (need[3:2] == KIND_REG && s1_cmd_reg.second_value[15:3] != '0)
            || (need[1:0] == KIND_REG && s1_cmd_reg.third_value[15:3] != '0))
        begin
            fault = FAULT_RANGE;
        end
    end

    always_comb
    begin
        alu      = op_a;
        wr_en    = 1'b0;
        is_load  = 1'b0;
        is_store = 1'b0;
        taken    = 1'b0;
        unique case (s1_cmd_reg.opcode)
            OP_MRR:  begin alu = op_a; wr_en = 1'b1; end
            OP_MVI:  begin alu = s1_cmd_reg.second_value; wr_en = 1'b1; end
            OP_LDMR: begin wr_en = 1'b1; is_load = 1'b1; end
            OP_STRM: is_store = 1'b1;
            OP_ADD:  begin alu = op_a + op_b; wr_en = 1'b1; end
            OP_SUB:  begin alu = op_a - op_b; wr_en = 1'b1; end
            OP_INC:  begin alu = op_a + 16'd1; wr_en = 1'b1; end
            OP_DEC:  begin alu = op_a - 16'd1; wr_en = 1'b1; end
            OP_AND:  begin alu = op_a & op_b; wr_en = 1'b1; end
            OP_OR:   begin alu = op_a | op_b; wr_en = 1'b1; end
            OP_XOR:  begin alu = op_a ^ op_b; wr_en = 1'b1; end
            OP_NOT:  begin alu = ~op_a; wr_en = 1'b1; end
            OP_JMP:  taken = 1'b1;
            OP_JZ:   taken = (op_b == 16'h0000);
            OP_JN:   taken = op_b[15];
            OP_OUT:  alu = op_a;
            default: alu = op_a;
        endcase
    end

    // jump target: offset plus signed immediate, reduced into the program
    assign jimm     = (s1_cmd_reg.opcode == OP_JMP) ? s1_cmd_reg.first_value
                                                    : s1_cmd_reg.second_value;
    assign jsum     = JT_W'(offset_reg) + {{(JT_W-16){jimm[15]}}, jimm} + JT_W'(PC_BIAS);
    assign jsum_ext = 32'(jsum);
    assign jtarget  = PC_W'(jsum_ext % PROGRAM_DEPTH);

    assign fetch_inc = (fetch_reg == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : fetch_reg + 1'b1;

    always_comb
    begin
        if (fault != FAULT_OK)
        begin
            fetch_next = fetch_reg;
        end
        else if (taken)
        begin
            fetch_next = jtarget;
        end
        else
        begin
            fetch_next = fetch_inc;
        end
    end

    assign fetch_ext = 32'(fetch_next);

    always_comb
    begin
        res_next                = '0;
        res_next.next_fetch     = fetch_ext[FETCH_W-1:0];
        res_next.fault_code     = fault;
        if (fault == FAULT_OK && s1_cmd_reg.opcode == OP_OUT)
        begin
            res_next.shown_valid    = 1'b1;
            res_next.shown_register = d_addr;
            res_next.shown_value    = op_b;
        end
    end

    // data RAM: clearing sweep after reset, then load and store
    assign ram_addr_ext = 32'(op_a);
    assign dmem_raddr   = DA_W'(ram_addr_ext % DATA_DEPTH);
    assign dmem_re      = adv && s1_valid_reg && fault == FAULT_OK && is_load;
    assign dmem_we      = clear_reg || (adv && s1_valid_reg && fault == FAULT_OK && is_store);
    assign dmem_waddr   = clear_reg ? clr_addr_reg : dmem_raddr;
    assign dmem_wdata   = clear_reg ? 16'h0000 : op_b;

    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            dmem[dmem_waddr] <= dmem_wdata;
        end
        if (dmem_re)
        begin
            dmem_q_reg <= dmem[dmem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == DA_W'(DATA_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            fetch_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_wr_en_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                offset_reg <= cfg_write_data;
                fetch_reg  <= PC_W'(32'(cfg_write_data) % PROGRAM_DEPTH);
            end
            else if (adv && s1_valid_reg)
            begin
                fetch_reg <= fetch_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s2_wr_en_reg <= s1_valid_reg && fault == FAULT_OK && wr_en;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (adv)
        begin
            s2_load_reg  <= is_load;
            s2_waddr_reg <= d_addr;
            s2_wdata_reg <= alu;
            s2_res_reg   <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !cmd_ready)
        else $error("word accepted during RAM clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> s1_valid_reg)
        else $error("accepted word lost before execute");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_res_reg.fault_code != FAULT_OK |-> !s2_wr_en_reg
            && !s2_res_reg.shown_valid)
        else $error("faulting word changes state or shows a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_wr_en_reg |-> s2_valid_reg)
        else $error("register write without a word in write-back");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

endmodule
